[rtl/cartridge_bank_mapper_with_scanline_irq_top_macros.svh]
// Assertion macros for the mapper RTL.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CBM_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mapper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBM_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mapper assertion failed");

`else

`define CBM_ASSERT_IMP(name, clk, rstn, ante, cons)
`define CBM_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

[rtl/cbm_pkg.sv]
package cbm_pkg;

  localparam int unsigned ChrSlots  = 8;
  localparam int unsigned ChrIdxW   = $clog2(ChrSlots);
  localparam int unsigned PrgSlots  = 4;
  localparam int unsigned BankW     = 9;
  localparam int unsigned CntW      = 4;

  localparam logic [CntW-1:0] CntPrgLast = CntW'(PrgSlots - 1);
  localparam logic [CntW-1:0] CntChrLast = CntW'(PrgSlots + ChrSlots - 1);

  // Event codes on the operation field.
  typedef enum logic [1:0] {
    OP_LOW  = 2'd0,
    OP_HIGH = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } cbm_op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PRG_COUNT   = 2'd0,
    CFG_CHR_PRESENT = 2'd1,
    CFG_FOUR_SCREEN = 2'd2,
    CFG_UNUSED      = 2'd3
  } cbm_cfg_e;

  // Mirroring codes on the result.
  localparam logic [1:0] MirVertical   = 2'd0;
  localparam logic [1:0] MirFourScreen = 2'd2;

  // Address decode.
  localparam logic [15:0] AddrExtPrg  = 16'h6000;
  localparam logic [15:0] AddrExtChr  = 16'h6001;
  localparam logic [15:0] AddrMask    = 16'hE001;
  localparam logic [15:0] AddrBankSel = 16'h8000;
  localparam logic [15:0] AddrBankDat = 16'h8001;
  localparam logic [15:0] AddrMirror  = 16'hA000;
  localparam logic [15:0] AddrIrqCnt  = 16'hC000;
  localparam logic [15:0] AddrIrqRld  = 16'hC001;
  localparam logic [15:0] AddrIrqOff  = 16'hE000;
  localparam logic [15:0] AddrIrqOn   = 16'hE001;

  localparam logic [2:0] SelMask      = 3'h7;
  localparam logic [7:0] ChrPairMask  = 8'hFE;
  localparam logic [8:0] LastScanline = 9'd239;

  // Bank-select register codes.
  localparam logic [2:0] SelChr0 = 3'd0;
  localparam logic [2:0] SelChr2 = 3'd1;
  localparam logic [2:0] SelChr4 = 3'd2;
  localparam logic [2:0] SelChr5 = 3'd3;
  localparam logic [2:0] SelChr6 = 3'd4;
  localparam logic [2:0] SelChr7 = 3'd5;
  localparam logic [2:0] SelPrg0 = 3'd6;
  localparam logic [2:0] SelPrg1 = 3'd7;

  // Scalar mapper state seen by the result sequencer.
  typedef struct packed {
    logic [7:0] bank_select;
    logic [7:0] prg_low_bank0;
    logic [7:0] prg_low_bank1;
    logic [7:0] ext_prg;
    logic       ext_chr;
    logic       irq_pending;
    logic       mirror_horizontal;
  } cbm_state_t;

  // One write into the character bank memory.
  typedef struct packed {
    logic               we;
    logic [ChrIdxW-1:0] idx;
    logic [7:0]         val;
  } cbm_chr_wr_t;

endpackage

[rtl/cartridge_bank_mapper_with_scanline_irq_top.sv]
// Bank mapper with scanline interrupt, with extended PRG and CHR bank bits.
// Input channel: one word per event (CPU register write or end-of-scanline tick), taken
// on a rising edge with in_valid_i high and in_stall_o low. Output channel: one word per
// slot, taken on a rising edge with out_valid_o high and out_stall_i low. Every event
// produces the four PRG slot words, then the eight CHR slot words when CHR ROM is
// present; last_o marks the final word of the event.
// A taken event is first registered in the slot sequencer, which then issues its words.
// Throughput: one word per cycle while out_stall_i is low; an event is 12 words (4
// without CHR ROM). The single output register sets the rate: one slot per cycle.
// The next event is taken on the edge that issues the last word of the current one.
// The eight CHR bank registers live in a small RAM with registered read; the read for
// the next slot is issued from cnt_d. Reset clears per-entry valid bits, so an
// entry never written reads back its own index; no clearing pass is needed.
// Reset puts every mapper register at its power-on value and configuration at 32 PRG
// banks, CHR ROM present and normal mirroring. While out_stall_i is high the output
// word holds and the slot sequencer waits. Configuration writes are always ready.
`include "cartridge_bank_mapper_with_scanline_irq_top_macros.svh"

module cartridge_bank_mapper_with_scanline_irq_top import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [8:0]  scanline_i,
  input  logic        rendering_enabled_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        target_o,
  output logic [2:0]  slot_o,
  output logic [8:0]  bank_o,
  output logic        irq_line_o,
  output logic [1:0]  mirroring_o,
  output logic        last_o
);

  // Configuration registers.
  logic [8:0] prg_count_q;
  logic       chr_present_q;
  logic       four_screen_q;
  cbm_cfg_e   cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cbm_cfg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q   <= 9'd32;
      chr_present_q <= 1'b1;
      four_screen_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_PRG_COUNT:   prg_count_q   <= cfg_data_i;
        CFG_CHR_PRESENT: chr_present_q <= cfg_data_i[0];
        CFG_FOUR_SCREEN: four_screen_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Slot sequencer. busy_q is high while an event still has words to issue; cnt_q
  // counts slots, PRG slots first, CHR slots after them.
  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_free;
  logic            issue;
  logic            last_issue;
  logic            in_accept;
  logic [CntW-1:0] cnt_last;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign issue      = busy_q && out_free;
  assign cnt_last   = chr_present_q ? CntChrLast : CntPrgLast;
  assign last_issue = issue && (cnt_q == cnt_last);
  assign in_stall_o = busy_q && !last_issue;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (issue) begin
      cnt_d = cnt_q + CntW'(1);
      if (last_issue) begin
        busy_d = 1'b0;
      end
    end
    if (in_accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Register update logic.
  cbm_state_t  st;
  cbm_chr_wr_t chr_wr;

  cbm_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .upd_i              (in_accept),
    .operation_i        (operation_i),
    .address_i          (address_i),
    .data_i             (data_i),
    .scanline_i         (scanline_i),
    .rendering_enabled_i(rendering_enabled_i),
    .four_screen_i      (four_screen_q),
    .state_o            (st),
    .chr_wr_o           (chr_wr)
  );

  // CHR bank memory. The read address follows the slot the sequencer will be at in the
  // next cycle, so the registered data lines up with cnt_q. Writes land before the first
  // CHR slot of the same event is read.
  logic [ChrIdxW-1:0] rd_idx, rd_idx_q;
  logic [7:0]         rd_data;
  logic [7:0]         chr_val;
  logic [ChrSlots-1:0] chr_vld_q;

  assign rd_idx = cnt_d[ChrIdxW-1:0] ^ {~st.bank_select[7], {(ChrIdxW-1){1'b0}}};

  cbm_ram #(
    .Width(8),
    .Depth(ChrSlots)
  ) u_chr_ram (
    .clk_i  (clk_i),
    .we_i   (chr_wr.we),
    .waddr_i(chr_wr.idx),
    .wdata_i(chr_wr.val),
    .raddr_i(rd_idx),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_vld_q <= '0;
    end else if (chr_wr.we) begin
      chr_vld_q[chr_wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx;
  end

  // An entry never written still holds its power-on value, which is its own index.
  assign chr_val = chr_vld_q[rd_idx_q] ? rd_data : 8'(rd_idx_q);

  // Bank number for the current slot.
  logic [8:0] n_minus2;
  logic [8:0] n_minus1;
  logic [8:0] ext_base;
  logic [8:0] prg_bank;
  logic [1:0] prg_slot;
  logic       is_chr;

  assign n_minus2 = prg_count_q - 9'd2;
  assign n_minus1 = prg_count_q - 9'd1;
  assign ext_base = {4'd0, st.ext_prg[3:0], 1'b0};
  assign prg_slot = cnt_q[1:0];
  assign is_chr   = cnt_q >= CntW'(PrgSlots);

  always_comb begin
    if (st.ext_prg[7]) begin
      prg_bank = ext_base + 9'(prg_slot);
    end else if (st.bank_select[6]) begin
      unique case (prg_slot)
        2'd0:    prg_bank = n_minus2;
        2'd1:    prg_bank = {1'b0, st.prg_low_bank1};
        2'd2:    prg_bank = {1'b0, st.prg_low_bank0};
        default: prg_bank = n_minus1;
      endcase
    end else begin
      unique case (prg_slot)
        2'd0:    prg_bank = {1'b0, st.prg_low_bank0};
        2'd1:    prg_bank = {1'b0, st.prg_low_bank1};
        2'd2:    prg_bank = n_minus2;
        default: prg_bank = n_minus1;
      endcase
    end
  end

  // Output register.
  logic       out_valid_q;
  logic       target_q;
  logic [2:0] slot_q;
  logic [8:0] bank_q;
  logic       irq_q;
  logic [1:0] mirror_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      target_q <= is_chr;
      slot_q   <= is_chr ? (cnt_q[2:0] ^ 3'b100) : {1'b0, prg_slot};
      bank_q   <= is_chr ? {st.ext_chr, chr_val} : prg_bank;
      irq_q    <= st.irq_pending;
      mirror_q <= four_screen_q ? MirFourScreen : (MirVertical | 2'(st.mirror_horizontal));
      last_q   <= last_issue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign target_o    = target_q;
  assign slot_o      = slot_q;
  assign bank_o      = bank_q;
  assign irq_line_o  = irq_q;
  assign mirroring_o = mirror_q;
  assign last_o      = last_q;

  // A new event is only taken when the previous one has issued its final word.
  `CBM_ASSERT_IMP(a_accept_gap, clk_i, rst_ni, in_accept, !busy_q || last_issue)
  // The slot counter never runs past the last CHR slot.
  `CBM_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, busy_q, cnt_q <= CntChrLast)
  // CHR slots are only issued when CHR ROM is present.
  `CBM_ASSERT_IMP(a_chr_present, clk_i, rst_ni, issue && is_chr, chr_present_q)
  // The word issued at the end of an event carries the last flag.
  `CBM_ASSERT_NXT(a_last_flag, clk_i, rst_ni, last_issue, out_valid_q && last_q)

endmodule

[rtl/cbm_ram.sv]
module cbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cbm_ctrl.sv]
module cbm_ctrl import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [8:0]  scanline_i,
  input  logic        rendering_enabled_i,
  input  logic        four_screen_i,
  output cbm_state_t  state_o,
  output cbm_chr_wr_t chr_wr_o
);

  logic [7:0] bank_select_q, bank_select_d;
  logic [7:0] prg0_q, prg0_d;
  logic [7:0] prg1_q, prg1_d;
  logic [7:0] ext_prg_q, ext_prg_d;
  logic       ext_chr_q, ext_chr_d;
  logic [7:0] irq_count_q, irq_count_d;
  logic [7:0] irq_reload_q, irq_reload_d;
  logic       irq_on_q, irq_on_d;
  logic       irq_pend_q, irq_pend_d;
  logic       mirror_h_q, mirror_h_d;

  // The paired character write is split into two memory writes; the odd half waits here.
  logic               wr2_vld_q, wr2_vld_d;
  logic [ChrIdxW-1:0] wr2_idx_q, wr2_idx_d;
  logic [7:0]         wr2_val_q, wr2_val_d;

  cbm_op_e     op;
  logic [15:0] hi_addr;
  logic [7:0]  pair_val;
  cbm_chr_wr_t wr_now;

  assign op       = cbm_op_e'(operation_i);
  assign hi_addr  = address_i & AddrMask;
  assign pair_val = data_i & ChrPairMask;

  always_comb begin
    bank_select_d = bank_select_q;
    prg0_d        = prg0_q;
    prg1_d        = prg1_q;
    ext_prg_d     = ext_prg_q;
    ext_chr_d     = ext_chr_q;
    irq_count_d   = irq_count_q;
    irq_reload_d  = irq_reload_q;
    irq_on_d      = irq_on_q;
    irq_pend_d    = irq_pend_q;
    mirror_h_d    = mirror_h_q;
    wr2_vld_d     = 1'b0;
    wr2_idx_d     = wr2_idx_q;
    wr2_val_d     = wr2_val_q;
    wr_now        = '{we: wr2_vld_q, idx: wr2_idx_q, val: wr2_val_q};

    if (upd_i) begin
      unique case (op)
        OP_LOW: begin
          if (address_i == AddrExtPrg) begin
            ext_prg_d = data_i;
          end else if (address_i == AddrExtChr) begin
            ext_chr_d = data_i[0];
          end
        end
        OP_HIGH: begin
          if (hi_addr == AddrBankSel) begin
            bank_select_d = data_i;
          end else if (hi_addr == AddrBankDat) begin
            unique case (bank_select_q[2:0] & SelMask)
              SelChr0: begin
                wr_now    = '{we: 1'b1, idx: ChrIdxW'(0), val: pair_val};
                wr2_vld_d = 1'b1;
                wr2_idx_d = ChrIdxW'(1);
                wr2_val_d = pair_val + 8'd1;
              end
              SelChr2: begin
                wr_now    = '{we: 1'b1, idx: ChrIdxW'(2), val: pair_val};
                wr2_vld_d = 1'b1;
                wr2_idx_d = ChrIdxW'(3);
                wr2_val_d = pair_val + 8'd1;
              end
              SelChr4: wr_now = '{we: 1'b1, idx: ChrIdxW'(4), val: data_i};
              SelChr5: wr_now = '{we: 1'b1, idx: ChrIdxW'(5), val: data_i};
              SelChr6: wr_now = '{we: 1'b1, idx: ChrIdxW'(6), val: data_i};
              SelChr7: wr_now = '{we: 1'b1, idx: ChrIdxW'(7), val: data_i};
              SelPrg0: prg0_d = data_i;
              SelPrg1: prg1_d = data_i;
              default: prg1_d = data_i;
            endcase
          end else if (hi_addr == AddrMirror) begin
            if (!four_screen_i) begin
              mirror_h_d = data_i[0];
            end
          end else if (hi_addr == AddrIrqCnt) begin
            irq_count_d = data_i;
            irq_on_d    = 1'b1;
          end else if (hi_addr == AddrIrqRld) begin
            irq_reload_d = data_i;
          end else if (hi_addr == AddrIrqOff) begin
            irq_on_d   = 1'b0;
            irq_pend_d = 1'b0;
          end else if (hi_addr == AddrIrqOn) begin
            irq_on_d = 1'b1;
          end
        end
        OP_TICK: begin
          if (scanline_i <= LastScanline && rendering_enabled_i && irq_on_q) begin
            if (irq_count_q == 8'd0) begin
              irq_count_d = irq_reload_q;
              irq_pend_d  = 1'b1;
            end else begin
              irq_count_d = irq_count_q - 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q <= '0;
      prg0_q        <= 8'd0;
      prg1_q        <= 8'd1;
      ext_prg_q     <= '0;
      ext_chr_q     <= 1'b0;
      irq_count_q   <= '0;
      irq_reload_q  <= '0;
      irq_on_q      <= 1'b0;
      irq_pend_q    <= 1'b0;
      mirror_h_q    <= 1'b0;
      wr2_vld_q     <= 1'b0;
    end else begin
      bank_select_q <= bank_select_d;
      prg0_q        <= prg0_d;
      prg1_q        <= prg1_d;
      ext_prg_q     <= ext_prg_d;
      ext_chr_q     <= ext_chr_d;
      irq_count_q   <= irq_count_d;
      irq_reload_q  <= irq_reload_d;
      irq_on_q      <= irq_on_d;
      irq_pend_q    <= irq_pend_d;
      mirror_h_q    <= mirror_h_d;
      wr2_vld_q     <= wr2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr2_idx_q <= wr2_idx_d;
    wr2_val_q <= wr2_val_d;
  end

  assign state_o = '{
    bank_select:       bank_select_q,
    prg_low_bank0:     prg0_q,
    prg_low_bank1:     prg1_q,
    ext_prg:           ext_prg_q,
    ext_chr:           ext_chr_q,
    irq_pending:       irq_pend_q,
    mirror_horizontal: mirror_h_q
  };
  assign chr_wr_o = wr_now;

endmodule

[tb/cbm_slot_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration, event and slot channels of the bank mapper. It keeps its
// own copy of the mapper registers, works out the slot words that each accepted event
// must produce, and compares every accepted slot word with the oldest one waiting.
module cbm_slot_checker import cbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [8:0]  scanline_i,
  input  logic        rendering_enabled_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        target_i,
  input  logic [2:0]  slot_i,
  input  logic [8:0]  bank_i,
  input  logic        irq_line_i,
  input  logic [1:0]  mirroring_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic       target;
    logic [2:0] slot;
    logic [8:0] bank;
    logic       irq;
    logic [1:0] mir;
    logic       last;
  } slot_word_t;

  // Configuration copy.
  logic [8:0] n_prg_banks;
  logic       chr_present;
  logic       four_scr;

  // Mapper register copy.
  logic [7:0] bank_sel;
  logic [7:0] prg0;
  logic [7:0] prg1;
  logic [7:0] ext_prg;
  logic       ext_chr;
  logic [7:0] chr_bank [ChrSlots];
  logic [7:0] irq_cnt;
  logic [7:0] irq_rld;
  logic       irq_en;
  logic       irq_pend;
  logic       mir_h;

  slot_word_t slot_map_q [$];
  slot_word_t seen_word;
  slot_word_t want_word;

  task automatic reset_mapper();
    int i;
    n_prg_banks = 9'd32;
    chr_present = 1'b1;
    four_scr    = 1'b0;
    bank_sel    = '0;
    prg0        = 8'd0;
    prg1        = 8'd1;
    ext_prg     = '0;
    ext_chr     = 1'b0;
    for (i = 0; i < ChrSlots; i++) chr_bank[i] = 8'(i);
    irq_cnt     = '0;
    irq_rld     = '0;
    irq_en      = 1'b0;
    irq_pend    = 1'b0;
    mir_h       = 1'b0;
  endtask

  task automatic write_mapper_reg(input logic [15:0] addr, input logic [7:0] data);
    case (addr & AddrMask)
      AddrBankSel: bank_sel = data;
      AddrBankDat: begin
        case (bank_sel[2:0] & SelMask)
          SelChr0: begin
            chr_bank[0] = data & ChrPairMask;
            chr_bank[1] = (data & ChrPairMask) + 8'd1;
          end
          SelChr2: begin
            chr_bank[2] = data & ChrPairMask;
            chr_bank[3] = (data & ChrPairMask) + 8'd1;
          end
          SelChr4: chr_bank[4] = data;
          SelChr5: chr_bank[5] = data;
          SelChr6: chr_bank[6] = data;
          SelChr7: chr_bank[7] = data;
          SelPrg0: prg0 = data;
          default: prg1 = data;
        endcase
      end
      AddrMirror: if (!four_scr) mir_h = data[0];
      AddrIrqCnt: begin
        irq_cnt = data;
        irq_en  = 1'b1;
      end
      AddrIrqRld: irq_rld = data;
      AddrIrqOff: begin
        irq_en   = 1'b0;
        irq_pend = 1'b0;
      end
      AddrIrqOn: irq_en = 1'b1;
      default: ;
    endcase
  endtask

  task automatic map_event(input logic [1:0] op, input logic [15:0] addr,
                           input logic [7:0] data, input logic [8:0] line, input logic rend);
    case (cbm_op_e'(op))
      OP_LOW: begin
        if (addr == AddrExtPrg) ext_prg = data;
        else if (addr == AddrExtChr) ext_chr = data[0];
      end
      OP_HIGH: write_mapper_reg(addr, data);
      OP_TICK: begin
        if (line <= LastScanline && rend && irq_en) begin
          if (irq_cnt == 8'd0) begin
            irq_cnt  = irq_rld;
            irq_pend = 1'b1;
          end else begin
            irq_cnt = irq_cnt - 8'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Queues the four program slot words and, with character ROM, the eight character ones.
  task automatic queue_slot_map();
    logic [8:0] prg_bank [PrgSlots];
    logic [8:0] n_minus2;
    logic [8:0] n_minus1;
    logic [2:0] src;
    slot_word_t w;
    int i;
    n_minus2 = n_prg_banks - 9'd2;
    n_minus1 = n_prg_banks - 9'd1;
    if (ext_prg[7]) begin
      for (i = 0; i < PrgSlots; i++) prg_bank[i] = {4'b0, ext_prg[3:0], 1'b0} + 9'(i);
    end else if (bank_sel[6]) begin
      prg_bank[0] = n_minus2;
      prg_bank[1] = {1'b0, prg1};
      prg_bank[2] = {1'b0, prg0};
      prg_bank[3] = n_minus1;
    end else begin
      prg_bank[0] = {1'b0, prg0};
      prg_bank[1] = {1'b0, prg1};
      prg_bank[2] = n_minus2;
      prg_bank[3] = n_minus1;
    end
    w.irq = irq_pend;
    w.mir = four_scr ? MirFourScreen : {1'b0, mir_h};
    for (i = 0; i < PrgSlots; i++) begin
      w.target = 1'b0;
      w.slot   = 3'(i);
      w.bank   = prg_bank[i];
      w.last   = !chr_present && i == PrgSlots - 1;
      slot_map_q.push_back(w);
    end
    if (chr_present) begin
      for (i = 0; i < ChrSlots; i++) begin
        src      = 3'(i) ^ (bank_sel[7] ? 3'd4 : 3'd0);
        w.target = 1'b1;
        w.slot   = 3'(i);
        w.bank   = {ext_chr, chr_bank[src]};
        w.last   = i == ChrSlots - 1;
        slot_map_q.push_back(w);
      end
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_mapper();
      slot_map_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cbm_cfg_e'(cfg_index_i))
          CFG_PRG_COUNT:   n_prg_banks = cfg_data_i;
          CFG_CHR_PRESENT: chr_present = cfg_data_i[0];
          CFG_FOUR_SCREEN: four_scr = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        seen_word.target = target_i;
        seen_word.slot   = slot_i;
        seen_word.bank   = bank_i;
        seen_word.irq    = irq_line_i;
        seen_word.mir    = mirroring_i;
        seen_word.last   = last_i;
        if (slot_map_q.size() == 0) begin
          $display("%0t: unexpected slot word, expected none, got %h", $time, seen_word);
          fail_count_o++;
        end else begin
          want_word = slot_map_q.pop_front();
          check_field("target", want_word.target, seen_word.target);
          check_field("slot", want_word.slot, seen_word.slot);
          check_field("bank", want_word.bank, seen_word.bank);
          check_field("irq_line", want_word.irq, seen_word.irq);
          check_field("mirroring", want_word.mir, seen_word.mir);
          check_field("last", want_word.last, seen_word.last);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        map_event(operation_i, address_i, data_i, scanline_i, rendering_enabled_i);
        queue_slot_map();
      end
      pending_o = slot_map_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the bank mapper. The checker instance beside the block does
// all the prediction and comparison; this module only produces event words, writes
// the configuration between phases, stalls the slot channel and decides pass or fail.
module tb_top import cbm_pkg::*; ();

  // A run is stopped when this many cycles pass without any word moving on any channel.
  // The longest legal quiet stretch is the forced receiver hold (HoldCycles).
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned PhaseItems    = 36;
  localparam int unsigned NumPhases     = 7;

  typedef struct packed {
    cbm_op_e     op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  line;
    logic        rend;
  } cpu_event_t;

  // Every input of the block has a known value from time zero.
  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        cfg_valid_i         = 1'b0;
  logic [1:0]  cfg_index_i         = CFG_PRG_COUNT;
  logic [8:0]  cfg_data_i          = '0;
  logic        in_valid_i          = 1'b0;
  logic [1:0]  operation_i         = OP_LOW;
  logic [15:0] address_i           = '0;
  logic [7:0]  data_i              = '0;
  logic [8:0]  scanline_i          = '0;
  logic        rendering_enabled_i = 1'b0;
  logic        out_stall_i         = 1'b0;

  logic        cfg_ready_o;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        target_o;
  logic [2:0]  slot_o;
  logic [8:0]  bank_o;
  logic        irq_line_o;
  logic [1:0]  mirroring_o;
  logic        last_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req     = 1'b0;

  always #6 clk_i = ~clk_i;

  cartridge_bank_mapper_with_scanline_irq_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .address_i,
    .data_i,
    .scanline_i,
    .rendering_enabled_i,
    .out_valid_o,
    .out_stall_i,
    .target_o,
    .slot_o,
    .bank_o,
    .irq_line_o,
    .mirroring_o,
    .last_o
  );

  cbm_slot_checker u_slot_check (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i          (in_stall_o),
    .operation_i,
    .address_i,
    .data_i,
    .scanline_i,
    .rendering_enabled_i,
    .out_valid_i         (out_valid_o),
    .out_stall_i,
    .target_i            (target_o),
    .slot_i              (slot_o),
    .bank_i              (bank_o),
    .irq_line_i          (irq_line_o),
    .mirroring_i         (mirroring_o),
    .last_i              (last_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending_words)
  );

  function automatic cpu_event_t make_event(input cbm_op_e op, input logic [15:0] addr,
                                            input logic [7:0] data, input logic [8:0] line,
                                            input logic rend);
    cpu_event_t ev;
    ev.op   = op;
    ev.addr = addr;
    ev.data = data;
    ev.line = line;
    ev.rend = rend;
    return ev;
  endfunction

  // Most random events are meaningful: counted ticks, writes to the decoded mapper
  // registers (with the don't-care address bits scrambled) and writes to the two
  // extension registers. Counter and reload values are kept small so that the
  // interrupt really fires. A small share is pure noise, including operation code 3.
  function automatic cpu_event_t rand_event();
    cpu_event_t ev;
    int unsigned pick;
    logic [15:0] base;
    ev.op   = OP_HIGH;
    ev.addr = 16'($urandom);
    ev.data = 8'($urandom);
    ev.line = 9'($urandom);
    ev.rend = 1'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 35) begin
      ev.op = OP_TICK;
      if ($urandom_range(0, 7) != 0) ev.line = 9'($urandom_range(0, 239));
      ev.rend = $urandom_range(0, 9) != 0;
    end else if (pick < 80) begin
      case ($urandom_range(0, 7))
        0: base = AddrBankSel;
        1: base = AddrBankDat;
        2: base = AddrMirror;
        3: base = AddrIrqCnt;
        4: base = AddrIrqRld;
        5: base = AddrIrqOff;
        6: base = AddrIrqOn;
        default: base = AddrBankDat;
      endcase
      ev.addr = base | (16'($urandom) & ~AddrMask);
      if ((base == AddrIrqCnt || base == AddrIrqRld) && $urandom_range(0, 3) != 0) begin
        ev.data = 8'($urandom_range(0, 6));
      end
    end else if (pick < 92) begin
      ev.op = OP_LOW;
      if ($urandom_range(0, 5) != 0) ev.addr = $urandom_range(0, 1) ? AddrExtPrg : AddrExtChr;
    end else begin
      ev.op = cbm_op_e'(2'($urandom_range(0, 3)));
    end
    return ev;
  endfunction

  // The sender works in bursts. Valid stays high across a burst; between bursts it
  // drops for a random gap. A zero gap keeps valid high so that it is never lowered
  // and raised in the same time step.
  task automatic send_word(input cpu_event_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i          <= 1'b1;
    operation_i         <= ev.op;
    address_i           <= ev.addr;
    data_i              <= ev.data;
    scanline_i          <= ev.line;
    rendering_enabled_i <= ev.rend;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits until every predicted slot word has come out. The count
  // is read at the falling edge, after the checker has settled. Returns on a rising
  // edge so that the caller can drive at once.
  task automatic drain_slot_words();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    @(posedge clk_i);
  endtask

  // The caller lowers cfg_valid_i after its last write, so back-to-back writes keep
  // valid high.
  task automatic write_cfg(input cbm_cfg_e idx, input logic [8:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Receiver: runs of a random stall style (never, light, half, heavy). When the
  // stimulus asks for pressure it holds off for a long fixed stretch so that the
  // block fills up and stalls its event input.
  initial begin : receiver
    int unsigned mode;
    int unsigned run;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(5, 60);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= $urandom_range(0, 3) == 0;
          2: out_stall_i <= 1'($urandom);
          default: out_stall_i <= $urandom_range(0, 3) != 0;
        endcase
      end
    end
  end

  // Watchdog: any word moving on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[cartridge_bank_mapper_with_scanline_irq_top] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    logic [8:0]  prg_count;
    logic        chr_on;
    logic        four_on;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset configuration. First the interrupt counter: a
    // tick with the counter disabled, then ticks that must not count (line above 239,
    // rendering off), a decrement, a reload with the interrupt raised, and the
    // acknowledge followed by re-enable.
    send_word(make_event(OP_TICK, 16'h0000, 8'h00, 9'd0, 1'b1));
    send_word(make_event(OP_HIGH, AddrIrqRld, 8'h02, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrIrqCnt, 8'h01, 9'd0, 1'b0));
    send_word(make_event(OP_TICK, 16'hFFFF, 8'hFF, 9'd240, 1'b1));
    send_word(make_event(OP_TICK, 16'h0000, 8'h00, 9'd5, 1'b0));
    send_word(make_event(OP_TICK, 16'h0000, 8'h00, 9'd0, 1'b1));
    send_word(make_event(OP_TICK, 16'h0000, 8'h00, LastScanline, 1'b1));
    send_word(make_event(OP_HIGH, AddrIrqOff, 8'h00, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrIrqOn, 8'h00, 9'd0, 1'b0));
    // Bank select with both mode bits set, then the paired character banks, the two
    // program banks and a single character bank.
    send_word(make_event(OP_HIGH, AddrBankSel, 8'hC0, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankDat, 8'hFF, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankSel, {5'h08, SelPrg0}, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankDat, 8'hAB, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankSel, {5'h00, SelPrg1}, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankDat, 8'h00, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankSel, {5'h10, SelChr4}, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrBankDat, 8'h33, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, AddrMirror, 8'h01, 9'd0, 1'b0));
    // Extension registers, then a low write to an unknown address, a high write
    // below the mapped range, operation code 3 and the all-ones address.
    send_word(make_event(OP_LOW, AddrExtChr, 8'hFF, 9'd0, 1'b0));
    send_word(make_event(OP_LOW, AddrExtPrg, 8'hFF, 9'd0, 1'b0));
    send_word(make_event(OP_LOW, AddrExtPrg, 8'h00, 9'd0, 1'b0));
    send_word(make_event(OP_LOW, 16'h6002, 8'hFF, 9'd0, 1'b0));
    send_word(make_event(OP_HIGH, 16'h7FFF, 8'h55, 9'd0, 1'b0));
    send_word(make_event(OP_NONE, 16'h8000, 8'hFF, 9'h1FF, 1'b1));
    send_word(make_event(OP_HIGH, 16'hFFFF, 8'hFF, 9'd0, 1'b0));

    // Random phases, each under its own configuration. The bank counts cover the
    // wrapping values 0 and 1, the minimum, the maximum and the all-ones value.
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_slot_words();
      case (phase)
        0: begin prg_count = 9'd0;   chr_on = 1'b1; four_on = 1'b0; end
        1: begin prg_count = 9'd1;   chr_on = 1'b0; four_on = 1'b1; end
        2: begin prg_count = 9'd2;   chr_on = 1'b1; four_on = 1'b1; end
        3: begin prg_count = 9'd256; chr_on = 1'b1; four_on = 1'b0; end
        4: begin prg_count = 9'd511; chr_on = 1'b0; four_on = 1'b0; end
        default: begin
          prg_count = 9'($urandom_range(2, 256));
          chr_on    = 1'($urandom);
          four_on   = 1'($urandom);
        end
      endcase
      write_cfg(CFG_PRG_COUNT, prg_count);
      write_cfg(CFG_CHR_PRESENT, {8'($urandom), chr_on});
      write_cfg(CFG_FOUR_SCREEN, {8'($urandom), four_on});
      if (phase == 0) write_cfg(CFG_UNUSED, 9'($urandom));
      cfg_valid_i <= 1'b0;
      // In one phase the receiver holds off while a long burst keeps arriving.
      if (phase == 3) begin
        hold_req   = 1'b1;
        burst_left = 60;
      end
      repeat (PhaseItems) send_word(rand_event());
    end

    drain_slot_words();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[cartridge_bank_mapper_with_scanline_irq_top] OK");
    end else begin
      $display("[cartridge_bank_mapper_with_scanline_irq_top] ERROR");
    end
    $finish;
  end

endmodule
